/* sv/sssp_pkg.sv */
// sssp_pkg: shared constants and word types for the shortest path search block
// no dependencies
package sssp_pkg;
   localparam int MaxVertices = 64;
   localparam int MaxEdges = 1024;
   localparam int WeightBits = 16;
   localparam int VertexBits = $clog2(MaxVertices);
   localparam int EdgeBits = $clog2(MaxEdges);
   localparam int DistBits = 22;
   localparam logic [DistBits-1:0] DistMax = '1;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_RUN   = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [5:0]  edge_from;
      logic [5:0]  edge_to;
      logic [15:0] edge_weight;
      logic [5:0]  source_vertex;
   } req_word_type;

   typedef struct packed {
      logic [5:0]  vertex;
      logic [21:0] distance;
      logic [63:0] pred_mask;
      logic        last;
   } rsp_word_type;
endpackage

/* sv/sssp_req_if.sv */
// sssp_req_if: valid/ready channel interfaces for request, response and csr words
// depends on sssp_pkg
interface sssp_req_if;
   logic valid;
   logic ready;
   sssp_pkg::req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sssp_rsp_if;
   logic valid;
   logic ready;
   sssp_pkg::rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sssp_csr_if;
   logic valid;
   logic ready;
   logic [6:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* sv/sssp_edge_store.sv */
// sssp_edge_store: edge memory, one write port and one registered read port
// depends on sssp_pkg
module sssp_edge_store (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [sssp_pkg::EdgeBits-1:0] wr_addr,
   input  logic [5:0]                   wr_tail,
   input  logic [5:0]                   wr_head,
   input  logic [sssp_pkg::WeightBits-1:0] wr_weight,
   input  logic [sssp_pkg::EdgeBits-1:0] rd_addr,
   output logic [5:0]                   rd_tail,
   output logic [5:0]                   rd_head,
   output logic [sssp_pkg::WeightBits-1:0] rd_weight
);
   import sssp_pkg::*;

   logic [6+6+WeightBits-1:0] mem [MaxEdges];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_tail, wr_head, wr_weight};
      end
      {rd_tail, rd_head, rd_weight} <= mem[rd_addr];
   end
endmodule

/* sv/single_source_shortest_paths_top.sv */
// single_source_shortest_paths_top: Dijkstra search block over a loaded edge store
// depends on sssp_pkg, the channel interfaces and sssp_edge_store
//
// A run word holds off requests while the search runs. Take N vertices, E stored
// edges and R vertices reached from the source (R <= N). The distance and pred
// rows are cleared first. Each of the R settle rounds is a scan over the
// distance memory for the nearest open vertex, then a pass over the edge memory.
// A final scan finds nothing left. Then N output words follow, each read and
// then loaded into the output register, and the receiver can stall them.
// Distances live in a one-port-read memory; an edge whose head was written by
// either of the last two write-backs is forwarded.
module single_source_shortest_paths_top (
   input  logic clock,
   input  logic reset,
   sssp_req_if.sink   req,
   sssp_rsp_if.source rsp,
   sssp_csr_if.sink   csr
);
   import sssp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_INIT, ST_SCAN, ST_EDGE, ST_OUT
   } state_type;

   state_type state_ff;
   logic [6:0] vcount_ff;
   logic [EdgeBits:0] ecount_ff;
   logic [VertexBits:0] n_ff;
   logic [VertexBits:0] idx_ff;
   logic [VertexBits-1:0] src_ff;
   logic [MaxVertices-1:0] reached_ff, settled_ff;
   logic [DistBits-1:0] dist_mem [MaxVertices];
   logic [MaxVertices-1:0] pred_mem [MaxVertices];
   logic [DistBits-1:0] rd_dist_ff;
   logic [MaxVertices-1:0] rd_pred_ff;
   logic [VertexBits-1:0] rd_addr_ff;
   logic rd_valid_ff;
   // best candidate during scan
   logic best_ok_ff;
   logic [VertexBits-1:0] best_ff;
   logic [DistBits-1:0] best_dist_ff;
   // current settled vertex
   logic [VertexBits-1:0] cur_ff;
   logic [DistBits-1:0] cur_dist_ff;
   // edge walk
   logic [EdgeBits:0] eaddr_ff;
   logic eval_ff;
   logic [5:0] e_tail, e_head;
   logic [WeightBits-1:0] e_weight;
   // edge fields delayed to line up with the head read
   logic [5:0] e_tail_ff;
   logic [WeightBits-1:0] e_weight_ff;
   // write-back of previous edge, used for forwarding
   logic wb_ff;
   logic [VertexBits-1:0] wb_addr_ff;
   logic [DistBits-1:0] wb_dist_ff;
   logic [MaxVertices-1:0] wb_pred_ff;
   // write-back landing in memory at the edge of the current read
   logic wb2_ff;
   logic [VertexBits-1:0] wb2_addr_ff;
   logic [DistBits-1:0] wb2_dist_ff;
   logic [MaxVertices-1:0] wb2_pred_ff;
   // output register
   logic rsp_valid_ff;
   rsp_word_type rsp_data_ff;

   logic req_fire;
   logic rsp_load;
   logic [EdgeBits-1:0] rd_eaddr;
   logic [DistBits:0] sum;
   logic [DistBits-1:0] nd;
   logic [DistBits-1:0] h_dist;
   logic [MaxVertices-1:0] h_pred;
   logic h_reached;
   logic [VertexBits-1:0] h_idx;
   logic [VertexBits-1:0] dist_rd_addr;
   logic edge_hit, edge_hit2;
   logic relax_go, relax_better, relax_equal;

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_data_ff;
   assign rsp_load = (state_ff == ST_OUT) && rd_valid_ff && (!rsp_valid_ff || rsp.ready);

   assign rd_eaddr = (state_ff == ST_EDGE) ? eaddr_ff[EdgeBits-1:0] : '0;

   sssp_edge_store u_edges (
      .clock     (clock),
      .wr_en     (req_fire && req.data.action == ACT_ADD && ecount_ff < (EdgeBits+1)'(MaxEdges)),
      .wr_addr   (ecount_ff[EdgeBits-1:0]),
      .wr_tail   (req.data.edge_from),
      .wr_head   (req.data.edge_to),
      .wr_weight (req.data.edge_weight[WeightBits-1:0]),
      .rd_addr   (rd_eaddr),
      .rd_tail   (e_tail),
      .rd_head   (e_head),
      .rd_weight (e_weight)
   );

   // distance/pred read address: scan index, edge head, or output index
   always_comb begin
      dist_rd_addr = idx_ff[VertexBits-1:0];
      if (state_ff == ST_EDGE) dist_rd_addr = e_head[VertexBits-1:0];
   end

   // relaxation data path with forwarding from the last two writes
   assign h_idx = rd_addr_ff;
   assign sum = {1'b0, cur_dist_ff} + (DistBits+1)'(e_weight_ff);
   assign nd = sum[DistBits] ? DistMax : sum[DistBits-1:0];
   always_comb begin
      edge_hit = wb_ff && wb_addr_ff == rd_addr_ff;
      edge_hit2 = wb2_ff && wb2_addr_ff == rd_addr_ff;
      h_dist = edge_hit ? wb_dist_ff : edge_hit2 ? wb2_dist_ff : rd_dist_ff;
      h_pred = edge_hit ? wb_pred_ff : edge_hit2 ? wb2_pred_ff : rd_pred_ff;
      h_reached = reached_ff[h_idx];
   end
   assign relax_go = rd_valid_ff && e_tail_ff == cur_ff && {1'b0, h_idx} < n_ff
                     && !settled_ff[h_idx];
   assign relax_better = !h_reached || nd < h_dist;
   assign relax_equal = nd == h_dist;

   // memory reads, registered
   always_ff @(posedge clock) begin
      rd_dist_ff <= dist_mem[dist_rd_addr];
      rd_pred_ff <= pred_mem[dist_rd_addr];
      rd_addr_ff <= dist_rd_addr;
      e_tail_ff <= e_tail;
      e_weight_ff <= e_weight;
      wb2_ff <= wb_ff;
      wb2_addr_ff <= wb_addr_ff;
      wb2_dist_ff <= wb_dist_ff;
      wb2_pred_ff <= wb_pred_ff;
      if (wb_ff) begin
         dist_mem[wb_addr_ff] <= wb_dist_ff;
         pred_mem[wb_addr_ff] <= wb_pred_ff;
      end
   end

   // control and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vcount_ff <= 7'd64;
         ecount_ff <= '0;
         rsp_valid_ff <= 1'b0;
         wb_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
         eval_ff <= 1'b0;
         reached_ff <= '0;
         settled_ff <= '0;
      end else begin
         if (csr.valid) vcount_ff <= csr.data;
         // output word valid: load or hand off
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               wb_ff <= 1'b0;
               if (req_fire) begin
                  unique case (req.data.action)
                     ACT_CLEAR: ecount_ff <= '0;
                     ACT_ADD: begin
                        if (ecount_ff < (EdgeBits+1)'(MaxEdges)) ecount_ff <= ecount_ff + 1'b1;
                     end
                     ACT_RUN: begin
                        if (vcount_ff == 7'd0) n_ff <= (VertexBits+1)'(1);
                        else if (vcount_ff > 7'(MaxVertices)) n_ff <= (VertexBits+1)'(MaxVertices);
                        else n_ff <= vcount_ff[VertexBits:0];
                        src_ff <= req.data.source_vertex[VertexBits-1:0];
                        idx_ff <= '0;
                        reached_ff <= '0;
                        settled_ff <= '0;
                        state_ff <= ST_INIT;
                     end
                     default: ;
                  endcase
               end
            end
            // clear pred rows, one per cycle; then seed source
            ST_INIT: begin
               wb_ff <= 1'b1;
               wb_addr_ff <= idx_ff[VertexBits-1:0];
               wb_dist_ff <= '0;
               wb_pred_ff <= '0;
               if (idx_ff == n_ff - 1'b1) begin
                  if ({1'b0, src_ff} < n_ff) reached_ff[src_ff] <= 1'b1;
                  idx_ff <= '0;
                  best_ok_ff <= 1'b0;
                  rd_valid_ff <= 1'b0;
                  state_ff <= ST_SCAN;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            // read each vertex distance, keep nearest open one
            ST_SCAN: begin
               wb_ff <= 1'b0;
               if (idx_ff < n_ff) idx_ff <= idx_ff + 1'b1;
               rd_valid_ff <= idx_ff < n_ff;
               if (rd_valid_ff && reached_ff[rd_addr_ff] && !settled_ff[rd_addr_ff]
                   && (!best_ok_ff || rd_dist_ff < best_dist_ff)) begin
                  best_ok_ff <= 1'b1;
                  best_ff <= rd_addr_ff;
                  best_dist_ff <= rd_dist_ff;
               end
               if (!rd_valid_ff && idx_ff == n_ff) begin
                  if (best_ok_ff) begin
                     settled_ff[best_ff] <= 1'b1;
                     cur_ff <= best_ff;
                     cur_dist_ff <= best_dist_ff;
                     eaddr_ff <= '0;
                     eval_ff <= 1'b0;
                     state_ff <= ST_EDGE;
                  end else begin
                     idx_ff <= '0;
                     state_ff <= ST_OUT;
                  end
               end
            end
            // edge pass: read edge, then head state, then relax
            ST_EDGE: begin
               if (eaddr_ff < ecount_ff) eaddr_ff <= eaddr_ff + 1'b1;
               eval_ff <= eaddr_ff < ecount_ff;
               rd_valid_ff <= eval_ff;
               wb_ff <= relax_go && (relax_better || relax_equal);
               wb_addr_ff <= h_idx;
               if (relax_go && relax_better) begin
                  reached_ff[h_idx] <= 1'b1;
                  wb_dist_ff <= nd;
                  wb_pred_ff <= MaxVertices'(1) << cur_ff;
               end else begin
                  wb_dist_ff <= h_dist;
                  wb_pred_ff <= h_pred | (MaxVertices'(1) << cur_ff);
               end
               if (!eval_ff && !rd_valid_ff && eaddr_ff == ecount_ff) begin
                  idx_ff <= '0;
                  best_ok_ff <= 1'b0;
                  state_ff <= ST_SCAN;
               end
            end
            // emit one word per vertex: read, then load output register
            ST_OUT: begin
               wb_ff <= 1'b0;
               if (!rsp_valid_ff || rsp.ready) begin
                  if (rd_valid_ff) begin
                     rsp_data_ff.vertex <= 6'(rd_addr_ff);
                     rsp_data_ff.distance <= (rd_pred_ff == '0) ? '0 : rd_dist_ff;
                     rsp_data_ff.pred_mask <= 64'(rd_pred_ff);
                     rsp_data_ff.last <= ({1'b0, rd_addr_ff} == n_ff - 1'b1);
                     rd_valid_ff <= 1'b0;
                     if ({1'b0, rd_addr_ff} == n_ff - 1'b1) state_ff <= ST_IDLE;
                  end else begin
                     rd_valid_ff <= 1'b1;
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            default: begin
               wb_ff <= 1'b0;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end
endmodule
